// ===== src/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int DATA_W   = 8;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                     valid;
    logic                     stay;
    logic [DATA_W-1:0]        data;
    logic signed [PRIO_W-1:0] prio;
  } cell_link_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic [DATA_W-1:0]        data;
    logic signed [PRIO_W-1:0] prio;
  } cell_ctrl_t;

endpackage

// ===== src/spq_in_if.sv =====
// input channel of the sorted priority queue
interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [DATA_W-1:0]        item_data;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (output valid, output command, output item_data, output item_priority,
                  input ready);
  modport sink   (input valid, input command, input item_data, input item_priority,
                  output ready);
endinterface

// ===== src/spq_out_if.sv =====
// result channel of the sorted priority queue
interface spq_out_if;
  import spq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DATA_W-1:0]     result_data;
  logic [STATUS_W-1:0]   status;
  logic [OCC_W-1:0]      occupancy;

  modport source (output valid, output result_data, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_data, input status, input occupancy,
                  output ready);
endinterface

// ===== src/sorted_priority_queue.sv =====
// sorted priority queue top level: chain of slot cells and result register
// Bounded priority queue of CAPACITY entries held in sorted order in a row of
// slot cells. Every transaction on the input channel yields exactly one result
// transaction. An enqueue places the byte behind all held entries of equal or
// lower priority value, so the lowest value is served first and ties leave in
// arrival order; a dequeue returns the front byte. Dequeue on an empty queue
// reports status 1, enqueue on a full queue is dropped with status 2. For
// each item, all cells compare the new priority in parallel and
// shift one slot in the same edge, and a result register parts the two
// channels, so a new transaction is taken every cycle while the result side
// keeps up. Occupancy reports the low 5 bits of the entry count. Reset clears
// the valid mark of every cell at once; there is no clearing pass.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  spq_in_if.sink  in_chan,
  spq_out_if.source out_chan
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_link_t links [CAPACITY];
  cell_link_t left_of [CAPACITY];
  cell_link_t right_of [CAPACITY];
  cell_ctrl_t ctrl;

  logic accept;
  logic full, empty;
  logic is_deq;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic [DATA_W-1:0]  result_data_r, result_data_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0]   occ_r;
  logic [CNT_W+OCC_W-1:0] count_wide;

  // take a transaction whenever the result register is free or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_deq        = (in_chan.command == CMD_DEQUEUE);

  // the valid marks are a solid run from slot 0
  assign full  = links[CAPACITY-1].valid;
  assign empty = !links[0].valid;

  assign ctrl.enq  = accept && !is_deq && !full;
  assign ctrl.deq  = accept && is_deq && !empty;
  assign ctrl.data = in_chan.item_data;
  assign ctrl.prio = in_chan.item_priority;

  // neighbor wiring: head sees an always-staying filled slot, tail an empty one
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign left_of[g] = '{valid: 1'b1, stay: 1'b1, data: '0, prio: '0};
      end else begin : g_mid_l
        assign left_of[g] = links[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_of[g] = '{valid: 1'b0, stay: 1'b0, data: '0, prio: '0};
      end else begin : g_mid_r
        assign right_of[g] = links[g+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_link  (left_of[g]),
        .right_link (right_of[g]),
        .own_link   (links[g])
      );
    end
  endgenerate

  // entry count follows the successful operations
  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result of the transaction being taken
  always_comb begin
    result_data_nxt = '0;
    status_nxt      = ST_DONE;
    if (is_deq) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        result_data_nxt = links[0].data;
      end
    end else if (full) begin
      status_nxt = ST_FULL;
    end
  end

  // low bits of the count after this item
  assign count_wide = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data_r <= result_data_nxt;
      status_r      <= status_nxt;
      occ_r         <= count_wide[OCC_W-1:0];
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_data = result_data_r;
  assign out_chan.status      = status_r;
  assign out_chan.occupancy   = occ_r;

endmodule

// ===== src/spq_cell.sv =====
// one slot of the sorted queue chain
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::cell_link_t left_link,
  input  spq_pkg::cell_link_t right_link,
  output spq_pkg::cell_link_t own_link
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [DATA_W-1:0]        data_r, data_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic                     stay;

  // entry keeps its slot when it is served no later than the new item
  assign stay = valid_r && (prio_r <= ctrl.prio);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (ctrl.enq) begin
      valid_nxt = valid_r | left_link.valid;
      if (!stay) begin
        if (left_link.stay) begin
          data_nxt = ctrl.data;
          prio_nxt = ctrl.prio;
        end else begin
          data_nxt = left_link.data;
          prio_nxt = left_link.prio;
        end
      end
    end else if (ctrl.deq) begin
      valid_nxt = right_link.valid;
      data_nxt  = right_link.data;
      prio_nxt  = right_link.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign own_link = '{valid: valid_r, stay: stay, data: data_r, prio: prio_r};

endmodule

// ===== src/spq_checker.sv =====
// port-level checks of the sorted priority queue and their bind
module spq_checker #(
  parameter int CAPACITY = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [spq_pkg::DATA_W-1:0]   result_data,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::OCC_W-1:0]    occupancy
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] CAP_LOW = OCC_W'(CAPACITY);

  // every taken transaction shows its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted transaction");

  // input side is never blocked while no result waits
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // an empty dequeue reports an empty queue and no data
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> occupancy == '0 && result_data == '0)
    else $error("empty status with nonzero occupancy or data");

  // a refused enqueue reports a full queue
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> occupancy == CAP_LOW && result_data == '0)
    else $error("full status with wrong occupancy or data");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_data) && $stable(status)
      && $stable(occupancy))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .result_data (out_chan.result_data),
  .status      (out_chan.status),
  .occupancy   (out_chan.occupancy)
);

// ===== dv/tb_top.sv =====
// self-checking testbench of the sorted priority queue against a shadow queue
module tb_top;
  import spq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 580;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either channel
  localparam int LONG_HOLD    = 120;   // one long receiver stall to back the block up
  localparam int SETTLE       = 4;     // result register plus margin
  localparam int MAX_PRINTS   = 40;

  typedef logic [DATA_W-1:0]        data_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
  } outcome_t;

  typedef struct {
    logic     cmd;
    data_t    data;
    prio_t    prio;
    bit       typed;  // expectation written out by hand
    outcome_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_chan();
  spq_out_if out_chan();

  sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  // shadow of the queue contents in serving order
  data_t shadow_data [CAPACITY];
  prio_t shadow_prio [CAPACITY];
  int    shadow_count = 0;

  outcome_t  awaited_results[$];
  stim_row_t directed_rows[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int enq_sent       = 0;
  int deq_sent       = 0;
  int full_refusals  = 0;
  int empty_reads    = 0;
  int peak_occ       = 0;
  int send_calm      = 0;
  int recv_calm      = 0;

  // one enqueue or dequeue applied to the shadow queue
  function automatic outcome_t queue_apply(logic cmd, data_t data, prio_t prio);
    outcome_t res;
    int       pos;
    res        = '0;
    res.status = ST_DONE;
    if (cmd == CMD_DEQUEUE) begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.data = shadow_data[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_data[i] = shadow_data[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
      end
    end else if (shadow_count >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      // behind every entry of equal or lower value, so ties keep arrival order
      pos = 0;
      while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
      for (int i = shadow_count; i > pos; i--) begin
        shadow_data[i] = shadow_data[i-1];
        shadow_prio[i] = shadow_prio[i-1];
      end
      shadow_data[pos] = data;
      shadow_prio[pos] = prio;
      shadow_count++;
    end
    res.occ = OCC_W'(shadow_count);
    return res;
  endfunction

  // mostly back to back or short gaps, a few long ones, now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(logic cmd, data_t data, prio_t prio, bit typed,
                         logic [STATUS_W-1:0] st, int occ);
    stim_row_t row;
    row.cmd         = cmd;
    row.data        = data;
    row.prio        = prio;
    row.typed       = typed;
    row.want.data   = '0;
    row.want.status = st;
    row.want.occ    = OCC_W'(occ);
    directed_rows.push_back(row);
  endtask

  // offer one transaction, hold it until taken, then predict its result
  task automatic offer(logic cmd, data_t data, prio_t prio, bit typed, outcome_t hand);
    outcome_t want;
    int       gap;
    in_chan.valid         <= 1'b1;
    in_chan.command       <= cmd;
    in_chan.item_data     <= data;
    in_chan.item_priority <= prio;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    want = queue_apply(cmd, data, prio);
    if (typed) want = hand;
    awaited_results.push_back(want);
    if (cmd == CMD_DEQUEUE) deq_sent++;
    else enq_sent++;
    if (want.status == ST_FULL) full_refusals++;
    if (want.status == ST_EMPTY) empty_reads++;
    if (shadow_count > peak_occ) peak_occ = shadow_count;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stimulus: directed table first, then random traffic in phases of varying mix
  initial begin
    int    enq_pct;
    int    r;
    logic  cmd;
    prio_t prio;
    in_chan.valid         <= 1'b0;
    in_chan.command       <= CMD_ENQUEUE;
    in_chan.item_data     <= '0;
    in_chan.item_priority <= '0;
    rst_n                 <= 1'b0;

    // dequeue on empty, extremes of priority, ties at both ends, fill up, refuse, drain some
    add_row(CMD_DEQUEUE, 8'h00, 16'sh0000, 1'b1, ST_EMPTY, 0);
    add_row(CMD_ENQUEUE, 8'hFF, 16'sh7FFF, 1'b1, ST_DONE, 1);
    add_row(CMD_ENQUEUE, 8'h00, 16'sh8000, 1'b1, ST_DONE, 2);
    add_row(CMD_ENQUEUE, 8'h5A, 16'sh0000, 1'b1, ST_DONE, 3);
    add_row(CMD_ENQUEUE, 8'hA5, 16'sh0000, 1'b1, ST_DONE, 4);
    add_row(CMD_ENQUEUE, 8'h11, 16'shFFFF, 1'b1, ST_DONE, 5);
    add_row(CMD_ENQUEUE, 8'h22, 16'sh7FFF, 1'b1, ST_DONE, 6);
    add_row(CMD_ENQUEUE, 8'h33, 16'sh8000, 1'b1, ST_DONE, 7);
    add_row(CMD_ENQUEUE, 8'h44, 16'sd100,  1'b1, ST_DONE, 8);
    add_row(CMD_ENQUEUE, 8'h55, -16'sd100, 1'b1, ST_DONE, 9);
    add_row(CMD_ENQUEUE, 8'h66, 16'sd1,    1'b1, ST_DONE, 10);
    add_row(CMD_ENQUEUE, 8'h77, -16'sd2,   1'b1, ST_DONE, 11);
    add_row(CMD_ENQUEUE, 8'h88, 16'sd0,    1'b1, ST_DONE, 12);
    add_row(CMD_ENQUEUE, 8'h99, 16'sd5000, 1'b1, ST_DONE, 13);
    add_row(CMD_ENQUEUE, 8'hAA, -16'sd5000, 1'b1, ST_DONE, 14);
    add_row(CMD_ENQUEUE, 8'hBB, 16'sh7FFE, 1'b1, ST_DONE, 15);
    add_row(CMD_ENQUEUE, 8'hCC, 16'sh8001, 1'b1, ST_DONE, 16);
    add_row(CMD_ENQUEUE, 8'hDD, 16'sh0000, 1'b1, ST_FULL, 16);
    add_row(CMD_DEQUEUE, 8'hFF, 16'sh7FFF, 1'b0, ST_DONE, 0);
    add_row(CMD_DEQUEUE, 8'h00, 16'sh0000, 1'b0, ST_DONE, 0);
    add_row(CMD_DEQUEUE, 8'h00, 16'sh0000, 1'b0, ST_DONE, 0);
    add_row(CMD_DEQUEUE, 8'h00, 16'sh0000, 1'b0, ST_DONE, 0);
    add_row(CMD_ENQUEUE, 8'hEE, 16'sh0000, 1'b0, ST_DONE, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      offer(directed_rows[k].cmd, directed_rows[k].data, directed_rows[k].prio,
            directed_rows[k].typed, directed_rows[k].want);

    enq_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // swing between filling, draining and balanced traffic
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 20;
          1: enq_pct = 50;
          2: enq_pct = 85;
          default: enq_pct = 65;
        endcase
      end
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
      // narrow band gives plenty of ties, a few at the extremes, rest anywhere
      r = $urandom_range(0, 9);
      if (r < 5) prio = prio_t'(int'($urandom_range(0, 6)) - 3);
      else if (r == 5) prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else prio = prio_t'($urandom);
      offer(cmd, data_t'($urandom), prio, 1'b0, '0);
    end

    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d transactions: %0d enqueue, %0d dequeue, %0d refused full, %0d on empty",
             enq_sent + deq_sent, enq_sent, deq_sent, full_refusals, empty_reads);
    $display("peak occupancy %0d of %0d, %0d results checked, %0d mismatches",
             peak_occ, CAPACITY, results_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("PASS sorted_priority_queue");
    else
      $display("FAIL sorted_priority_queue");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    bit held;
    int gap;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end
      gap = pick_gap(recv_calm);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // result checker: oldest expectation against each result transaction
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited, occupancy", out_chan.occupancy, -1);
      end else begin
        want = awaited_results.pop_front();
        if (out_chan.result_data !== want.data)
          report_mismatch("result_data", out_chan.result_data, want.data);
        if (out_chan.status !== want.status)
          report_mismatch("status", out_chan.status, want.status);
        if (out_chan.occupancy !== want.occ)
          report_mismatch("occupancy", out_chan.occupancy, want.occ);
      end
    end
  end

  // watchdog: too long without any transaction means the block is stuck
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               idle_cycles, awaited_results.size());
      $display("FAIL sorted_priority_queue");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_in_if.sv
src/spq_out_if.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
dv/tb_top.sv
